// ===== rtl/midi_uart_port_with_cmd_ack_macros.svh =====
// assertion helpers for the midi uart port
`ifndef MIDI_UART_PORT_WITH_CMD_ACK_MACROS_SVH
`define MIDI_UART_PORT_WITH_CMD_ACK_MACROS_SVH

// condition holds at every clock edge outside reset
`define MUCP_ASSERT_ALWAYS(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("mucp invariant violated");

// antecedent at one edge implies consequent at the next edge
`define MUCP_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mucp next-cycle check failed");

`endif

// ===== rtl/mucp_pkg.sv =====
package mucp_pkg;

	// item kinds
	localparam logic [1:0] KIND_READ    = 2'd0;
	localparam logic [1:0] KIND_WRITE   = 2'd1;
	localparam logic [1:0] KIND_RX_BYTE = 2'd2;
	localparam logic [1:0] KIND_TX_DONE = 2'd3;

	// ports
	localparam logic PORT_DATA = 1'b0;
	localparam logic PORT_CTRL = 1'b1;

	localparam logic [7:0] ACK_BYTE    = 8'hfe;
	localparam logic [7:0] SR_RX_EMPTY = 8'h80;
	localparam logic [7:0] SR_TX_BUSY  = 8'h40;
	localparam logic [7:0] CMD_RESET   = 8'hff;
	localparam logic [7:0] CMD_UART    = 8'h3f;
	localparam logic [7:0] EMPTY_READ  = 8'hff;

	// control broadcast to every fifo cell
	typedef struct packed {
		logic       clear;
		logic       shift;
		logic       push;
		logic [7:0] push_data;
	} cell_ctl_t;

endpackage

// ===== rtl/mucp_cell.sv =====
module mucp_cell import mucp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctl_t  ctl,
	input  logic       prev_valid,  // neighbor toward the head holds a byte
	input  logic       next_valid,  // neighbor toward the tail
	input  logic [7:0] next_data,
	output logic       valid,
	output logic [7:0] data
);

	logic       valid_q;
	logic [7:0] data_q;
	logic       own;
	logic       valid_d;
	logic [7:0] data_d;

	assign own = valid_q & ~ctl.clear;

	always_comb begin
		valid_d = own;
		data_d  = data_q;
		if (ctl.shift) begin
			valid_d = next_valid;
			data_d  = next_data;
		end else if (ctl.push && prev_valid && !own) begin
			// first free cell takes the new byte
			valid_d = 1'b1;
			data_d  = ctl.push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

// ===== rtl/midi_uart_port_with_cmd_ack.sv =====
// channel | direction | tdata (low bit up)                          | tuser
// s       | in        | write_value[7:0], line_byte[15:8]           | kind[1:0], port[2]
// m       | out       | read_value[7:0], send_byte[15:8],           | send_strobe[0]
//         |           | rx_pending[16], dropped[17], zero pad       |
//
// one item per cycle unless output stalls, one result per item, the cycle after acceptance
// receive fifo is a row of RX_DEPTH cells; a pop shifts every cell toward the head
// in the same cycle, a push lands in the first empty cell
// the output register frees the input whenever the result is taken or the register is empty
// reset clears the cell valid bits, uart mode and tx busy at once; no clearing pass
module midi_uart_port_with_cmd_ack import mucp_pkg::*; #(
	parameter int RX_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // write_value[7:0], line_byte[15:8]
	input  logic [2:0]  s_tuser,   // kind[1:0], port[2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // read_value[7:0], send_byte[15:8], rx_pending[16], dropped[17]
	output logic [0:0]  m_tuser    // send_strobe[0]
);

	localparam logic [RX_DEPTH-1:0] ONE_V = RX_DEPTH'(1);

	// input fields
	logic [1:0] kind;
	logic       port;
	logic [7:0] write_value;
	logic [7:0] line_byte;

	assign kind        = s_tuser[1:0];
	assign port        = s_tuser[2];
	assign write_value = s_tdata[7:0];
	assign line_byte   = s_tdata[15:8];

	logic fire;
	logic out_valid_q;

	assign s_tready = ~out_valid_q | m_tready;
	assign fire     = s_tvalid & s_tready;

	// control state
	logic uart_mode_q;
	logic tx_busy_q;

	// fifo cells
	logic [RX_DEPTH-1:0] cell_valid;
	logic [7:0]          cell_data [RX_DEPTH];
	cell_ctl_t           ctl;

	logic fifo_empty;
	logic fifo_full;
	assign fifo_empty = ~cell_valid[0];
	assign fifo_full  = cell_valid[RX_DEPTH-1];

	// per-item decode
	logic       push_req;
	logic [7:0] rd_c;
	logic       strobe_c;
	logic [7:0] sbyte_c;
	logic       drop_c;
	logic       pend_c;
	logic       uart_d;
	logic       busy_d;

	always_comb begin
		ctl        = '0;
		push_req   = 1'b0;
		rd_c       = '0;
		strobe_c   = 1'b0;
		sbyte_c    = '0;
		uart_d     = uart_mode_q;
		busy_d     = tx_busy_q;
		unique case (kind)
			KIND_READ: begin
				if (port == PORT_DATA) begin
					// pop, or 0xff on an empty fifo
					ctl.shift = ~fifo_empty;
					rd_c      = fifo_empty ? EMPTY_READ : cell_data[0];
				end else begin
					rd_c = (fifo_empty ? SR_RX_EMPTY : 8'h00) |
						(tx_busy_q ? SR_TX_BUSY : 8'h00);
				end
			end
			KIND_WRITE: begin
				if (port == PORT_DATA) begin
					if (!tx_busy_q) begin
						strobe_c = 1'b1;
						sbyte_c  = write_value;
						busy_d   = 1'b1;
					end
				end else if (write_value == CMD_RESET) begin
					// reset command: empty fifo, leave uart mode, ack only from
					// intelligent mode
					ctl.clear     = 1'b1;
					uart_d        = 1'b0;
					push_req      = ~uart_mode_q;
					ctl.push_data = ACK_BYTE;
				end else if (!uart_mode_q) begin
					if (write_value == CMD_UART) begin
						uart_d = 1'b1;
					end
					push_req      = 1'b1;
					ctl.push_data = ACK_BYTE;
				end
			end
			KIND_RX_BYTE: begin
				push_req      = uart_mode_q;
				ctl.push_data = line_byte;
			end
			KIND_TX_DONE: begin
				busy_d = 1'b0;
			end
			default: begin
			end
		endcase
		ctl.push = push_req;

		// a data write while busy is lost
		drop_c = (kind == KIND_WRITE) & (port == PORT_DATA) & tx_busy_q;
		// a push into a full fifo is lost; a cleared fifo is never full
		if (push_req && fifo_full && !ctl.clear) begin
			drop_c = 1'b1;
		end

		// whether the fifo holds a byte after this item
		if (ctl.clear) begin
			pend_c = push_req;
		end else if (ctl.shift) begin
			pend_c = cell_valid[1];
		end else if (push_req) begin
			pend_c = 1'b1;
		end else begin
			pend_c = cell_valid[0];
		end

		// nothing moves unless the item is taken
		if (!fire) begin
			ctl.clear = 1'b0;
			ctl.shift = 1'b0;
			ctl.push  = 1'b0;
		end
	end

	// chain of fifo cells
	for (genvar i = 0; i < RX_DEPTH; i++) begin : g_cell
		logic       prev_in;
		logic       next_v;
		logic [7:0] next_d;

		if (i == 0) begin : g_head
			assign prev_in = 1'b1;
		end else begin : g_body
			assign prev_in = cell_valid[i-1] & ~ctl.clear;
		end

		if (i == RX_DEPTH - 1) begin : g_tail
			assign next_v = 1'b0;
			assign next_d = '0;
		end else begin : g_link
			assign next_v = cell_valid[i+1];
			assign next_d = cell_data[i+1];
		end

		mucp_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.prev_valid (prev_in),
			.next_valid (next_v),
			.next_data  (next_d),
			.valid      (cell_valid[i]),
			.data       (cell_data[i])
		);
	end

	// mode and transmitter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uart_mode_q <= 1'b0;
			tx_busy_q   <= 1'b0;
		end else if (fire) begin
			uart_mode_q <= uart_d;
			tx_busy_q   <= busy_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	logic [23:0] out_data_q;
	logic        out_strobe_q;

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q   <= {6'b0, drop_c, pend_c, sbyte_c, rd_c};
			out_strobe_q <= strobe_c;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_strobe_q;

	`include "midi_uart_port_with_cmd_ack_macros.svh"

	// occupied cells always form a run from the head
	`MUCP_ASSERT_ALWAYS(a_cells_packed, ((cell_valid + ONE_V) & cell_valid) == '0)
	// reported interrupt matches the fifo left behind by the item
	`MUCP_ASSERT_NEXT(a_pending_match, fire, m_tdata[16] == cell_valid[0])
	// a started transmit leaves the transmitter busy
	`MUCP_ASSERT_NEXT(a_strobe_busy, fire && strobe_c, tx_busy_q && m_tuser[0])

endmodule
